// ===== src/iplpm_pkg.sv =====
package iplpm_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 64;
    localparam logic [7:0] HOST_LEN = 8'd128;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_ROUTE  = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic scan_clr;  // reset scan index
        logic scan_step; // evaluate one entry, advance index
        logic commit;    // apply table update and build result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rd_pending; // read data for a stepped entry still to evaluate
        logic scan_last;  // index reached the last entry
    } t_sts;

    // 128-bit prefix mask of length len (0..128)
    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++) begin
            m[127 - b] = (8'(b) < len);
        end
        return m;
    endfunction

endpackage

// ===== src/iplpm_ctrl.sv =====
module iplpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output iplpm_pkg::t_cmd o_cmd,
    input  iplpm_pkg::t_sts i_sts
);
    import iplpm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DONE = 5'b00100,
        S_CMT  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                // last read data arrives here
                o_cmd.scan_step = i_sts.rd_pending;
                n_state = S_CMT;
            end
            S_CMT: begin
                // accumulators now hold every entry
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output both open");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMT) |=> (r_state == S_OUT)) else $error("commit skipped output");
endmodule

// ===== src/iplpm_dpath.sv =====
module iplpm_dpath #(
    parameter int unsigned ENTRIES = iplpm_pkg::ENTRIES_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iplpm_pkg::t_cmd i_cmd,
    output iplpm_pkg::t_sts o_sts,
    input  logic [1:0]      i_op,
    input  logic [63:0]     i_addr_hi,
    input  logic [63:0]     i_addr_lo,
    input  logic [7:0]      i_prefix_len,
    input  logic [11:0]     i_vlan,
    input  logic [63:0]     i_gw_hi,
    input  logic [63:0]     i_gw_lo,
    output logic [1:0]      o_status,
    output logic            o_connected,
    output logic [11:0]     o_out_vlan,
    output logic [63:0]     o_next_hop_hi,
    output logic [63:0]     o_next_hop_lo,
    output logic [7:0]      o_match_len
);
    import iplpm_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned MW = 128 + 8 + 12 + 128;

    // entry memory: prefix, length, vlan, gateway
    logic [MW-1:0] r_mem [ENTRIES];
    logic [MW-1:0] r_rd;
    logic [ENTRIES-1:0] r_valid;

    // captured request
    t_op          r_op;
    logic [127:0] r_addr, r_pfx;
    logic [7:0]   r_len;
    logic [11:0]  r_vlan;
    logic [127:0] r_gw;

    // scan state
    logic [IW-1:0] r_idx, r_rd_idx;
    logic          r_rd_v;
    logic          r_hit_ex, r_hit_best, r_free_f;
    logic [IW-1:0] r_ex_idx, r_free_idx;
    logic [7:0]    r_blen;
    logic [11:0]   r_b_vlan;
    logic [127:0]  r_b_gw;
    logic [11:0]   r_ex_vlan;
    logic [127:0]  r_ex_gw;

    // default route
    logic          r_dflt_v;
    logic [11:0]   r_dflt_vlan;
    logic [127:0]  r_dflt_gw;

    logic [7:0]   len_sat;
    logic [127:0] e_pfx, e_gw;
    logic [7:0]   e_len;
    logic [11:0]  e_vlan;
    logic         e_ok, e_exact, e_route;

    assign len_sat = (i_prefix_len > HOST_LEN) ? HOST_LEN : i_prefix_len;
    assign {e_pfx, e_len, e_vlan, e_gw} = r_rd;
    assign e_ok    = r_rd_v && r_valid[r_rd_idx];
    assign e_exact = e_ok && (e_len == r_len) && (e_pfx == r_pfx);
    assign e_route = e_ok && ((r_addr & prefix_mask(e_len)) == e_pfx) && (e_len > r_blen);

    assign o_sts.scan_last  = (r_idx == IW'(ENTRIES - 1));
    assign o_sts.rd_pending = r_rd_v;

    // registered memory read, one entry per cycle
    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[r_idx];
        r_rd_idx <= r_idx;
    end

    // request capture and scan accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_addr <= {i_addr_hi, i_addr_lo};
            r_pfx  <= {i_addr_hi, i_addr_lo} & prefix_mask(len_sat);
            r_len  <= len_sat;
            r_vlan <= i_vlan;
            r_gw   <= {i_gw_hi, i_gw_lo};
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
            r_hit_ex <= 1'b0;
            r_hit_best <= 1'b0;
            r_free_f <= 1'b0;
            r_blen <= '0;
        end else if (i_cmd.scan_step) begin
            if (!o_sts.scan_last) r_idx <= r_idx + 1'b1;
            if (e_exact && !r_hit_ex) begin
                r_hit_ex  <= 1'b1;
                r_ex_idx  <= r_rd_idx;
                r_ex_vlan <= e_vlan;
                r_ex_gw   <= e_gw;
            end
            if (e_route) begin
                r_hit_best <= 1'b1;
                r_blen     <= e_len;
                r_b_vlan   <= e_vlan;
                r_b_gw     <= e_gw;
            end
            if (r_rd_v && !r_valid[r_rd_idx] && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
    end

    // read data is live for the cycle after each stepped address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_v <= 1'b0;
        else          r_rd_v <= i_cmd.scan_step && !(r_rd_v && o_sts.scan_last
                                && r_rd_idx == IW'(ENTRIES - 1));
    end

    // table update
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == OP_ADD && r_len != 8'd0 && !r_hit_ex && r_free_f)
            r_mem[r_free_idx] <= {r_pfx, r_len, r_vlan, r_gw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dflt_v <= 1'b0;
        end else if (i_cmd.commit) begin
            unique case (r_op)
                OP_ADD: begin
                    if (r_len == 8'd0) r_dflt_v <= 1'b1;
                    else if (!r_hit_ex && r_free_f) r_valid[r_free_idx] <= 1'b1;
                end
                OP_DELETE: begin
                    if (r_len == 8'd0) r_dflt_v <= 1'b0;
                    else if (r_hit_ex) r_valid[r_ex_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == OP_ADD && r_len == 8'd0) begin
            r_dflt_vlan <= r_vlan;
            r_dflt_gw   <= r_gw;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status <= ST_MISS;
            o_connected <= 1'b0;
            o_out_vlan <= '0;
            {o_next_hop_hi, o_next_hop_lo} <= '0;
            o_match_len <= '0;
            unique case (r_op)
                OP_ADD: begin
                    if (r_len == 8'd0) o_status <= ST_OK;
                    else if (r_hit_ex) o_status <= ST_DUP;
                    else if (r_free_f) o_status <= ST_OK;
                    else o_status <= ST_FULL;
                end
                OP_DELETE: begin
                    if ((r_len == 8'd0) ? r_dflt_v : r_hit_ex) o_status <= ST_OK;
                end
                OP_GET: begin
                    if (r_len == 8'd0) begin
                        if (r_dflt_v) begin
                            o_status <= ST_OK;
                            o_out_vlan <= r_dflt_vlan;
                            {o_next_hop_hi, o_next_hop_lo} <= r_dflt_gw;
                        end
                    end else if (r_hit_ex) begin
                        o_status <= ST_OK;
                        o_out_vlan <= r_ex_vlan;
                        {o_next_hop_hi, o_next_hop_lo} <= r_ex_gw;
                        o_match_len <= r_len;
                    end
                end
                OP_ROUTE: begin
                    if (r_hit_best) begin
                        o_status <= ST_OK;
                        o_out_vlan <= r_b_vlan;
                        if (r_b_gw == '0) begin
                            o_connected <= 1'b1;
                            {o_next_hop_hi, o_next_hop_lo} <= r_addr;
                            o_match_len <= HOST_LEN;
                        end else begin
                            {o_next_hop_hi, o_next_hop_lo} <= r_b_gw;
                            o_match_len <= r_blen;
                        end
                    end else if (r_dflt_v) begin
                        o_status <= ST_OK;
                        o_out_vlan <= r_dflt_vlan;
                        {o_next_hop_hi, o_next_hop_lo} <= r_dflt_gw;
                    end
                end
                default: ;
            endcase
        end
    end

    a_best_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_hit_best || r_blen != 8'd0))
        else $error("best match with zero length");
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.load) |-> (r_len <= HOST_LEN)) else $error("length not saturated");
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_rd_v) else $error("commit with read in flight");
endmodule

// ===== src/ipv6_longest_prefix_route_table.sv =====
// Channel | Handshake                 | Payload
// input   | i_in_valid / o_in_ready   | i_op, i_addr_*, i_prefix_len, i_vlan, i_gw_*
// output  | o_out_valid / i_out_ready | o_status, o_connected, o_out_vlan, o_next_hop_*, o_match_len
// One request at a time: from transfer in to result valid the block walks
// the entry memory, one registered read per cycle, then uses S_DONE for the
// last read and S_CMT to commit.
// The result is held until its transfer; the next request can be taken in
// the cycle after, so a new request is only taken once the last one is out.
// Synchronous active-low reset clears all valid bits and the default route;
// no clearing pass is needed.
module ipv6_longest_prefix_route_table #(
    parameter int unsigned ENTRIES = iplpm_pkg::ENTRIES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [7:0]  i_prefix_len,
    input  logic [11:0] i_vlan,
    input  logic [63:0] i_gw_hi,
    input  logic [63:0] i_gw_lo,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_connected,
    output logic [11:0] o_out_vlan,
    output logic [63:0] o_next_hop_hi,
    output logic [63:0] o_next_hop_lo,
    output logic [7:0]  o_match_len
);
    import iplpm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    iplpm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(cmd), .i_sts(sts)
    );

    iplpm_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_op, .i_addr_hi, .i_addr_lo, .i_prefix_len, .i_vlan, .i_gw_hi, .i_gw_lo,
        .o_status, .o_connected, .o_out_vlan, .o_next_hop_hi, .o_next_hop_lo,
        .o_match_len
    );
endmodule

// ===== verif/tb.sv =====
module tb;
    import iplpm_pkg::*;

    localparam int unsigned SLOTS = 64;
    localparam int unsigned POOL = 20;
    localparam int unsigned TAIL_ITEMS = 60;
    localparam longint unsigned CYCLE_LIMIT = 600000;

    typedef struct {
        t_op         op;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  len;
        logic [11:0] vlan;
        logic [63:0] gw_hi;
        logic [63:0] gw_lo;
    } t_request;

    typedef struct {
        t_status     status;
        logic        connected;
        logic [11:0] vlan;
        logic [63:0] nh_hi;
        logic [63:0] nh_lo;
        logic [7:0]  mlen;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = '0;
    logic [63:0] i_addr_hi = '0;
    logic [63:0] i_addr_lo = '0;
    logic [7:0]  i_prefix_len = '0;
    logic [11:0] i_vlan = '0;
    logic [63:0] i_gw_hi = '0;
    logic [63:0] i_gw_lo = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_connected;
    logic [11:0] o_out_vlan;
    logic [63:0] o_next_hop_hi;
    logic [63:0] o_next_hop_lo;
    logic [7:0]  o_match_len;

    ipv6_longest_prefix_route_table #(.ENTRIES(SLOTS)) dut (.*);

    // mirror of the route table
    logic        rt_valid [SLOTS];
    logic [63:0] rt_hi [SLOTS];
    logic [63:0] rt_lo [SLOTS];
    logic [7:0]  rt_len [SLOTS];
    logic [11:0] rt_vlan [SLOTS];
    logic [63:0] rt_gw_hi [SLOTS];
    logic [63:0] rt_gw_lo [SLOTS];
    logic        dflt_valid;
    logic [11:0] dflt_vlan;
    logic [63:0] dflt_gw_hi;
    logic [63:0] dflt_gw_lo;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int unsigned mismatches = 0;
    int unsigned answers_seen = 0;
    longint unsigned cycles = 0;
    logic tail_mode = 1'b0;
    logic stimulus_done = 1'b0;

    logic [63:0] pool_hi [POOL];
    logic [63:0] pool_lo [POOL];
    logic [7:0]  pool_len [POOL];

    function automatic logic [63:0] upper_mask(input int unsigned len);
        if (len >= 64) return '1;
        if (len == 0) return '0;
        return ~64'd0 << (64 - len);
    endfunction

    function automatic logic [63:0] lower_mask(input int unsigned len);
        if (len <= 64) return '0;
        if (len >= 128) return '1;
        return ~64'd0 << (128 - len);
    endfunction

    function automatic int find_prefix(input logic [63:0] hi, input logic [63:0] lo,
                                       input logic [7:0] len);
        for (int i = 0; i < SLOTS; i++)
            if (rt_valid[i] && rt_len[i] == len && rt_hi[i] == hi && rt_lo[i] == lo)
                return i;
        return -1;
    endfunction

    // apply one request to the mirror and work out its answer
    function automatic t_answer route_table_apply(input t_request r);
        t_answer a;
        int unsigned len;
        logic [63:0] phi, plo;
        int k, best;
        int unsigned blen;
        a = '{ST_MISS, 1'b0, 12'd0, 64'd0, 64'd0, 8'd0};
        len = (r.len > 128) ? 128 : r.len;
        phi = r.addr_hi & upper_mask(len);
        plo = r.addr_lo & lower_mask(len);
        case (r.op)
            OP_ADD: begin
                if (len == 0) begin
                    dflt_valid = 1'b1;
                    dflt_vlan = r.vlan;
                    dflt_gw_hi = r.gw_hi;
                    dflt_gw_lo = r.gw_lo;
                    a.status = ST_OK;
                end else if (find_prefix(phi, plo, 8'(len)) >= 0) begin
                    a.status = ST_DUP;
                end else begin
                    a.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!rt_valid[i]) begin
                            rt_valid[i] = 1'b1;
                            rt_hi[i] = phi;
                            rt_lo[i] = plo;
                            rt_len[i] = 8'(len);
                            rt_vlan[i] = r.vlan;
                            rt_gw_hi[i] = r.gw_hi;
                            rt_gw_lo[i] = r.gw_lo;
                            a.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (len == 0) begin
                    if (dflt_valid) begin
                        dflt_valid = 1'b0;
                        a.status = ST_OK;
                    end
                end else begin
                    k = find_prefix(phi, plo, 8'(len));
                    if (k >= 0) begin
                        rt_valid[k] = 1'b0;
                        a.status = ST_OK;
                    end
                end
            end
            OP_GET: begin
                if (len == 0) begin
                    if (dflt_valid)
                        a = '{ST_OK, 1'b0, dflt_vlan, dflt_gw_hi, dflt_gw_lo, 8'd0};
                end else begin
                    k = find_prefix(phi, plo, 8'(len));
                    if (k >= 0)
                        a = '{ST_OK, 1'b0, rt_vlan[k], rt_gw_hi[k], rt_gw_lo[k], rt_len[k]};
                end
            end
            default: begin
                best = -1;
                blen = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (rt_valid[i] && rt_len[i] > blen &&
                        (r.addr_hi & upper_mask(rt_len[i])) == rt_hi[i] &&
                        (r.addr_lo & lower_mask(rt_len[i])) == rt_lo[i]) begin
                        best = i;
                        blen = rt_len[i];
                    end
                end
                if (best >= 0) begin
                    // zero gateway: connected, answer with the destination itself
                    if (rt_gw_hi[best] == 0 && rt_gw_lo[best] == 0)
                        a = '{ST_OK, 1'b1, rt_vlan[best], r.addr_hi, r.addr_lo, HOST_LEN};
                    else
                        a = '{ST_OK, 1'b0, rt_vlan[best], rt_gw_hi[best], rt_gw_lo[best],
                              8'(blen)};
                end else if (dflt_valid) begin
                    a = '{ST_OK, 1'b0, dflt_vlan, dflt_gw_hi, dflt_gw_lo, 8'd0};
                end
            end
        endcase
        return a;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_req(input t_op op, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [7:0] len, input logic [63:0] ghi,
                            input logic [63:0] glo);
        t_request r;
        r = '{op, hi, lo, len, 12'($urandom()), ghi, glo};
        pending_reqs.push_back(r);
    endtask

    // random item aimed at the pool of known prefixes
    task automatic push_random();
        int unsigned sel, p, pick;
        logic [63:0] mh, ml, ghi, glo;
        p = $urandom_range(0, POOL - 1);
        pick = $urandom_range(0, 99);
        mh = upper_mask(pool_len[p] > 128 ? 128 : pool_len[p]);
        ml = lower_mask(pool_len[p] > 128 ? 128 : pool_len[p]);
        ghi = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
        glo = (ghi == 0) ? 64'd0 : rand64();
        if (pick < 35)
            push_req(OP_ADD, pool_hi[p] | (rand64() & ~mh), pool_lo[p] | (rand64() & ~ml),
                     pool_len[p], ghi, glo);
        else if (pick < 50)
            push_req(OP_DELETE, pool_hi[p], pool_lo[p], pool_len[p], rand64(), rand64());
        else if (pick < 65)
            push_req(OP_GET, pool_hi[p], pool_lo[p], pool_len[p], rand64(), rand64());
        else if (pick < 93)
            push_req(OP_ROUTE, (pool_hi[p] & mh) | (rand64() & ~mh),
                     (pool_lo[p] & ml) | (rand64() & ~ml), 8'($urandom()), rand64(), rand64());
        else begin
            sel = $urandom_range(0, 3);
            push_req(t_op'(sel), rand64(), rand64(), 8'($urandom()), rand64(), rand64());
        end
    endtask

    // clock and reset
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus
    initial begin
        logic [63:0] fill_hi [70];
        logic [63:0] fill_lo [70];
        logic [63:0] a1;
        a1 = rand64();
        for (int i = 0; i < POOL; i++) begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
            pool_len[i] = (i < 3) ? 8'd0 : (i < 5) ? 8'd128 : (i == 5) ? 8'd200
                          : 8'($urandom_range(1, 128));
        end
        // directed: empty table, default route, extremes, connected and duplicate
        push_req(OP_ROUTE, a1, rand64(), 8'd0, '0, '0);
        push_req(OP_DELETE, a1, '0, 8'd0, '0, '0);
        push_req(OP_GET, '0, '0, 8'd0, '0, '0);
        push_req(OP_ADD, '1, '1, 8'd0, '1, '1);
        push_req(OP_GET, '0, '0, 8'd0, '0, '0);
        push_req(OP_ADD, a1, 64'h1234, 8'd128, '0, '0);
        push_req(OP_ADD, a1, '1, 8'd64, 64'd1, 64'd2);
        push_req(OP_ADD, '1, '1, 8'd1, '0, 64'd5);
        push_req(OP_ADD, 64'h5, 64'h5, 8'd255, '1, '0);
        push_req(OP_ADD, a1, 64'h99, 8'd64, 64'd7, 64'd7);
        push_req(OP_ROUTE, a1, 64'h1234, 8'd3, '0, '0);
        push_req(OP_ROUTE, a1, 64'h4321, 8'd0, '0, '0);
        push_req(OP_ROUTE, 64'h8000_0000_0000_0000, '0, 8'd0, '0, '0);
        push_req(OP_ROUTE, '0, '0, 8'd0, '0, '0);
        push_req(OP_GET, a1, 64'h1234, 8'd128, '0, '0);
        push_req(OP_GET, 64'h5, 64'h5, 8'd129, '0, '0);
        push_req(OP_GET, a1, '0, 8'd64, '0, '0);
        push_req(OP_DELETE, a1, '0, 8'd64, '0, '0);
        push_req(OP_DELETE, a1, '0, 8'd64, '0, '0);
        push_req(OP_ADD, '0, '0, 8'd0, '0, '0);
        push_req(OP_ROUTE, '0, '1, 8'd0, '0, '0);
        push_req(OP_ADD, '0, '0, 8'd65, '1, '1);
        push_req(OP_ROUTE, '0, 64'h7fff_ffff_ffff_ffff, 8'd0, '0, '0);
        push_req(OP_DELETE, '1, '1, 8'd0, '0, '0);
        for (int i = 0; i < 150; i++) push_random();
        // fill the table past its capacity, then delete every fill entry again
        for (int i = 0; i < 70; i++) begin
            fill_hi[i] = rand64();
            fill_lo[i] = rand64();
            push_req(OP_ADD, fill_hi[i], fill_lo[i], 8'd128, rand64(), rand64());
        end
        for (int i = 0; i < 70; i++)
            push_req(OP_DELETE, fill_hi[i], fill_lo[i], 8'd128, '0, '0);
        for (int i = 0; i < 110; i++) push_random();
        stimulus_done = 1'b1;
    end

    // driver
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r = '{t_op'(i_op), i_addr_hi, i_addr_lo, i_prefix_len, i_vlan, i_gw_hi,
                      i_gw_lo};
                expected_answers.push_back(route_table_apply(r));
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (stimulus_done && pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    i_op <= r.op;
                    i_addr_hi <= r.addr_hi;
                    i_addr_lo <= r.addr_lo;
                    i_prefix_len <= r.len;
                    i_vlan <= r.vlan;
                    i_gw_hi <= r.gw_hi;
                    i_gw_lo <= r.gw_lo;
                    i_in_valid <= 1'b1;
                    tail_mode <= (pending_reqs.size() < TAIL_ITEMS);
                    if (!tail_mode && $urandom_range(0, 2) == 0)
                        send_gap <= $urandom_range(1, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    int unsigned hold = 0;
    logic long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer, status %0d", o_status);
                end else begin
                    e = expected_answers.pop_front();
                    if (o_status !== e.status || o_connected !== e.connected ||
                        o_out_vlan !== e.vlan || o_next_hop_hi !== e.nh_hi ||
                        o_next_hop_lo !== e.nh_lo || o_match_len !== e.mlen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: exp st %0d conn %0d vlan %h ",
                                      "nh %h_%h len %0d / got st %0d conn %0d vlan %h ",
                                      "nh %h_%h len %0d"}, answers_seen,
                                     e.status, e.connected, e.vlan, e.nh_hi, e.nh_lo,
                                     e.mlen, o_status, o_connected, o_out_vlan,
                                     o_next_hop_hi, o_next_hop_lo, o_match_len);
                    end
                end
            end
            if (hold > 0) begin
                hold <= hold - 1;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && answers_seen == 100) begin
                // long stall so the block backs up onto its input
                long_hold_done <= 1'b1;
                hold <= 400;
                i_out_ready <= 1'b0;
            end else if (!tail_mode && $urandom_range(0, 5) == 0) begin
                hold <= $urandom_range(0, 16);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** ipv6_longest_prefix_route_table: FAILED **");
            $finish;
        end
    end

    // end of run
    initial begin
        wait (stimulus_done && i_rst_n);
        wait (pending_reqs.size() == 0 && !i_in_valid && expected_answers.size() == 0);
        repeat (SLOTS + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("** ipv6_longest_prefix_route_table: PASSED **");
        else
            $display("** ipv6_longest_prefix_route_table: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/iplpm_pkg.sv
src/iplpm_ctrl.sv
src/iplpm_dpath.sv
src/ipv6_longest_prefix_route_table.sv
verif/tb.sv
